// File: hw/rtl/msl_pkg.sv
// Package for the motor speed loop: widths, limits, register indexes,
// controller states and the controller-to-datapath command bundle.
// No dependencies.
package msl_pkg;

  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned ErrW     = 18;
  localparam int unsigned OpW      = 21;             // signed multiplier operand A
  localparam int unsigned ProdW    = OpW + CfgW + 1; // signed A times unsigned B
  localparam int unsigned SumW     = ProdW + 2;      // sum of three products
  localparam int unsigned AccW     = 16;
  localparam int unsigned DriveW   = 8;
  localparam int unsigned MagW     = 7;
  localparam int unsigned CompareW = 10;

  localparam logic signed [ProdW-1:0] SpeedLimit = ProdW'(32512);
  localparam logic signed [SumW-1:0]  AccLimit   = SumW'(25344);
  localparam logic [MagW-1:0]         DriveMax   = MagW'(99);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegTargetSpeed = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGainP       = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainI       = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGainD       = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSpeedScale  = 3'd4;

  // Register reset values
  localparam logic [CfgW-1:0] TargetSpeedReset = 16'd256;
  localparam logic [CfgW-1:0] GainPReset       = 16'd1280;
  localparam logic [CfgW-1:0] GainIReset       = 16'd128;
  localparam logic [CfgW-1:0] GainDReset       = 16'd563;
  localparam logic [CfgW-1:0] SpeedScaleReset  = 16'd4855;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SPEED,
    S_ERROR,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_SUM,
    S_ACC,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    MUL_SPEED,
    MUL_P,
    MUL_I,
    MUL_D
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;   // latch count, form delta
    logic     mul_en;    // register a product
    mul_sel_t mul_sel;
    logic     load_err;  // form speed and errors, shift error history
    logic     sum_load;  // sum takes product
    logic     sum_add;   // sum adds product
    logic     load_acc;  // update clamped accumulator
    logic     load_out;  // capture result transaction
  } cmd_t;

endpackage

// File: hw/rtl/motor_speed_loop_pid_pwm_unit.sv
// Motor speed loop: encoder delta to speed, incremental PID, PWM bridge drive.
// Each transaction runs through the controller states in turn, and the next one is
// taken only back in idle, since the single multiplier is shared by four products.
// Next input is taken while a finished result still waits in the output register.
// Reset (synchronous, rst high): registers to defaults, loop state to zero.
// Depends on msl_pkg, msl_ctrl and msl_datapath.
module motor_speed_loop_pid_pwm_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [msl_pkg::CfgIdxW-1:0]          cfg_index,
  input  logic [msl_pkg::CfgW-1:0]             cfg_data,
  // input channel: one control tick per transaction
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [msl_pkg::CountW-1:0]    encoder_count,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [msl_pkg::CountW-1:0]    measured_speed,
  output logic signed [msl_pkg::DriveW-1:0]    drive_value,
  output logic [msl_pkg::CompareW-1:0]         pwm_compare,
  output logic                                 reverse_pin,
  output logic                                 brake
);
  import msl_pkg::*;

  cmd_t cmd;

  // Register writes are always taken; an index beyond the list is dropped
  // by the datapath decode.
  assign cfg_ready = 1'b1;

  msl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  msl_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .encoder_count  (encoder_count),
    .measured_speed (measured_speed),
    .drive_value    (drive_value),
    .pwm_compare    (pwm_compare),
    .reverse_pin    (reverse_pin),
    .brake          (brake)
  );

endmodule

// File: hw/rtl/msl_ctrl.sv
// Controller state machine for the motor speed loop.
// Sequences the shared multiplier in the datapath and owns the input and result handshakes.
// Depends on msl_pkg.
module msl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output msl_pkg::cmd_t cmd
);
  import msl_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.mul_sel    = MUL_SPEED;
    in_ready       = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_SPEED;
        end
      end
      S_SPEED: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SPEED;
        state_next  = S_ERROR;
      end
      S_ERROR: begin
        cmd.load_err = 1'b1;
        state_next   = S_MUL_P;
      end
      S_MUL_P: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_P;
        state_next  = S_MUL_I;
      end
      S_MUL_I: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_I;
        cmd.sum_load = 1'b1;
        state_next   = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_D;
        cmd.sum_add = 1'b1;
        state_next  = S_SUM;
      end
      S_SUM: begin
        cmd.sum_add = 1'b1;
        state_next  = S_ACC;
      end
      S_ACC: begin
        cmd.load_acc = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/msl_datapath.sv
// Datapath for the motor speed loop: configuration registers, loop state,
// one shared signed multiplier, accumulator clamp and PWM mapping.
// Depends on msl_pkg.
module msl_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  msl_pkg::cmd_t                        cmd,
  input  logic                                 cfg_we,
  input  logic [msl_pkg::CfgIdxW-1:0]          cfg_index,
  input  logic [msl_pkg::CfgW-1:0]             cfg_data,
  input  logic signed [msl_pkg::CountW-1:0]    encoder_count,
  output logic signed [msl_pkg::CountW-1:0]    measured_speed,
  output logic signed [msl_pkg::DriveW-1:0]    drive_value,
  output logic [msl_pkg::CompareW-1:0]         pwm_compare,
  output logic                                 reverse_pin,
  output logic                                 brake
);
  import msl_pkg::*;

  logic signed [CfgW-1:0]   target_speed;
  logic [CfgW-1:0]          gain_p, gain_i, gain_d, speed_scale;

  logic [CountW-1:0]        previous_count;
  logic signed [CountW-1:0] delta;
  logic signed [ErrW-1:0]   error_last, error_before_last;
  logic signed [AccW-1:0]   output_accumulator;

  logic signed [CountW-1:0] speed;
  logic signed [OpW-1:0]    err, diff1, diff2;
  logic signed [ProdW-1:0]  prod;
  logic signed [SumW-1:0]   sum;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_speed <= TargetSpeedReset;
      gain_p       <= GainPReset;
      gain_i       <= GainIReset;
      gain_d       <= GainDReset;
      speed_scale  <= SpeedScaleReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegTargetSpeed: target_speed <= cfg_data;
        RegGainP:       gain_p       <= cfg_data;
        RegGainI:       gain_i       <= cfg_data;
        RegGainD:       gain_d       <= cfg_data;
        RegSpeedScale:  speed_scale  <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared multiplier operands
  logic signed [OpW-1:0]  mul_a;
  logic [CfgW-1:0]        mul_b;
  logic signed [ProdW-1:0] mul_y;

  always_comb begin
    case (cmd.mul_sel)
      MUL_SPEED: begin
        mul_a = OpW'(delta);
        mul_b = speed_scale;
      end
      MUL_P: begin
        mul_a = diff1;
        mul_b = gain_p;
      end
      MUL_I: begin
        mul_a = err;
        mul_b = gain_i;
      end
      MUL_D: begin
        mul_a = diff2;
        mul_b = gain_d;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_y = ProdW'(mul_a) * $signed({1'b0, mul_b});
  end

  // speed from product: floor divide by 256, then saturate
  logic signed [ProdW-1:0]  prod_shr;
  logic signed [CountW-1:0] speed_sat;
  logic signed [OpW-1:0]    err_now;

  always_comb begin
    prod_shr = prod >>> 8;
    if (prod_shr > SpeedLimit) begin
      speed_sat = CountW'(SpeedLimit);
    end else if (prod_shr < -SpeedLimit) begin
      speed_sat = CountW'(-SpeedLimit);
    end else begin
      speed_sat = prod_shr[CountW-1:0];
    end
    err_now = OpW'(target_speed) - OpW'(speed_sat);
  end

  // accumulator update
  logic signed [SumW-1:0] acc_sum;
  logic signed [AccW-1:0] acc_clamped;

  always_comb begin
    acc_sum = SumW'(output_accumulator) + (sum >>> 8);
    if (acc_sum > AccLimit) begin
      acc_clamped = AccW'(AccLimit);
    end else if (acc_sum < -AccLimit) begin
      acc_clamped = AccW'(-AccLimit);
    end else begin
      acc_clamped = acc_sum[AccW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_count     <= '0;
      error_last         <= '0;
      error_before_last  <= '0;
      output_accumulator <= '0;
    end else begin
      if (cmd.load_in) begin
        previous_count <= encoder_count;
      end
      if (cmd.load_err) begin
        error_before_last <= error_last;
        error_last        <= err_now[ErrW-1:0];
      end
      if (cmd.load_acc) begin
        output_accumulator <= acc_clamped;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      delta <= encoder_count - previous_count;
    end
    if (cmd.mul_en) begin
      prod <= mul_y;
    end
    if (cmd.load_err) begin
      speed <= speed_sat;
      err   <= err_now;
      diff1 <= err_now - OpW'(error_last);
      diff2 <= err_now - (OpW'(error_last) <<< 1) + OpW'(error_before_last);
    end
    if (cmd.sum_load) begin
      sum <= SumW'(prod);
    end else if (cmd.sum_add) begin
      sum <= sum + SumW'(prod);
    end
  end

  // drive and PWM mapping from the accumulator
  logic [AccW-1:0]     acc_abs;
  logic [MagW-1:0]     mag, cmp_base;
  logic                acc_neg;
  logic [CompareW-1:0] cmp;

  always_comb begin
    acc_neg  = output_accumulator[AccW-1];
    acc_abs  = acc_neg ? AccW'(-output_accumulator) : AccW'(output_accumulator);
    mag      = acc_abs[AccW-2 -: MagW];
    cmp_base = acc_neg ? mag : (DriveMax - mag);
    cmp      = ({3'b000, cmp_base} << 3) + ({3'b000, cmp_base} << 1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      measured_speed <= speed;
      drive_value    <= acc_neg ? DriveW'(mag) : -DriveW'(mag);
      if (mag == '0) begin
        pwm_compare <= '0;
        reverse_pin <= 1'b1;
        brake       <= 1'b1;
      end else begin
        pwm_compare <= cmp;
        reverse_pin <= !acc_neg;
        brake       <= 1'b0;
      end
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for motor_speed_loop_pid_pwm_unit: directed table, then random
// phases; results checked against an in-bench PID speed-loop predictor or a typed row.
// Depends on msl_pkg and the RTL of the unit.
module testbench;
  import msl_pkg::*;

  localparam int unsigned CycleLimit  = 400_000;
  localparam int unsigned RandPhases  = 10;
  localparam int unsigned TicksPerPhase = 48;
  localparam int unsigned SettleCycles = 20;

  // Register indexes past the last register: the unit must ignore writes there
  localparam logic [CfgIdxW-1:0] RegSpare5 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpare7 = 3'd7;

  typedef struct packed {
    logic signed [CountW-1:0] speed;
    logic signed [DriveW-1:0] drive;
    logic [CompareW-1:0]      compare;
    logic                     rev;
    logic                     brk;
  } tick_result_t;

  typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgW-1:0]     value;   // register data or encoder count
    logic                typed;   // expected result written into the row
    tick_result_t        res;
  } stim_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CfgIdxW-1:0]         cfg_index = '0;
  logic [CfgW-1:0]            cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [CountW-1:0]   encoder_count = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [CountW-1:0]   measured_speed;
  logic signed [DriveW-1:0]   drive_value;
  logic [CompareW-1:0]        pwm_compare;
  logic                       reverse_pin;
  logic                       brake;

  motor_speed_loop_pid_pwm_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .encoder_count  (encoder_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .measured_speed (measured_speed),
    .drive_value    (drive_value),
    .pwm_compare    (pwm_compare),
    .reverse_pin    (reverse_pin),
    .brake          (brake)
  );

  always #2 clk = ~clk;

  // Loop registers and state mirrored by the predictor
  logic signed [CfgW-1:0]   pid_target;
  logic [CfgW-1:0]          pid_kp;
  logic [CfgW-1:0]          pid_ki;
  logic [CfgW-1:0]          pid_kd;
  logic [CfgW-1:0]          pid_scale;
  logic [CountW-1:0]        pid_prev_count;
  logic signed [ErrW-1:0]   pid_err1;
  logic signed [ErrW-1:0]   pid_err2;
  logic signed [AccW-1:0]   pid_acc;

  tick_result_t pending_ticks[$];   // predicted results, oldest first
  int           errors = 0;
  bit           calm = 1'b0;        // no idling on either side while set
  logic [CountW-1:0] last_count = '0;

  // Apply one register write to the mirrored configuration; spare indexes do nothing
  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    case (idx)
      RegTargetSpeed: pid_target = data;
      RegGainP:       pid_kp = data;
      RegGainI:       pid_ki = data;
      RegGainD:       pid_kd = data;
      RegSpeedScale:  pid_scale = data;
      default: ;
    endcase
  endfunction

  // Advance the loop by one control tick and return the drive it produces
  function automatic tick_result_t pid_tick(logic [CountW-1:0] cnt);
    logic signed [CountW-1:0] delta;
    longint spd, e, e1, e2, inc, acc, mag, drv;
    tick_result_t r;
    delta = cnt - pid_prev_count;
    pid_prev_count = cnt;
    // floor division by 256 is an arithmetic right shift
    spd = (longint'(delta) * longint'(pid_scale)) >>> 8;
    if (spd > longint'(SpeedLimit)) spd = longint'(SpeedLimit);
    if (spd < -longint'(SpeedLimit)) spd = -longint'(SpeedLimit);
    e = longint'(pid_target) - spd;
    e1 = pid_err1;
    e2 = pid_err2;
    inc = (longint'(pid_kp) * (e - e1) + longint'(pid_ki) * e
           + longint'(pid_kd) * (e - 2 * e1 + e2)) >>> 8;
    acc = longint'(pid_acc) + inc;
    if (acc > longint'(AccLimit)) acc = longint'(AccLimit);
    if (acc < -longint'(AccLimit)) acc = -longint'(AccLimit);
    pid_acc = acc[AccW-1:0];
    pid_err2 = pid_err1;
    pid_err1 = e[ErrW-1:0];
    // truncate toward zero, then negate: encoder runs against the motor
    mag = (acc < 0 ? -acc : acc) / 256;
    drv = acc < 0 ? mag : -mag;
    r.speed = spd[CountW-1:0];
    r.drive = drv[DriveW-1:0];
    if (drv == 0) begin
      r.compare = '0;
      r.rev = 1'b1;
      r.brk = 1'b1;
    end else if (drv > 0) begin
      r.compare = CompareW'(drv * 10);
      r.rev = 1'b0;
      r.brk = 1'b0;
    end else begin
      r.compare = CompareW'((longint'(DriveMax) + drv) * 10);
      r.rev = 1'b1;
      r.brk = 1'b0;
    end
    return r;
  endfunction

  // Gap length: mostly none, sometimes short, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic tick_result_t res(logic signed [CountW-1:0] speed,
                                       logic signed [DriveW-1:0] drive,
                                       logic [CompareW-1:0] compare, logic rev, logic brk);
    res = '{speed, drive, compare, rev, brk};
  endfunction

  function automatic stim_row_t tick_row(logic [CountW-1:0] cnt);
    tick_row = '{ROW_TICK, RegTargetSpeed, cnt, 1'b0, tick_result_t'('0)};
  endfunction

  function automatic stim_row_t typed_row(logic [CountW-1:0] cnt, tick_result_t r);
    typed_row = '{ROW_TICK, RegTargetSpeed, cnt, 1'b1, r};
  endfunction

  function automatic stim_row_t reg_row(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    reg_row = '{ROW_REG, idx, data, 1'b0, tick_result_t'('0)};
  endfunction

  // Random register value: extremes, reset value, a full-range draw or a moderate setting
  function automatic logic [CfgW-1:0] pick_value(logic [CfgIdxW-1:0] idx);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) begin
      case (idx)
        RegTargetSpeed: return TargetSpeedReset;
        RegGainP:       return GainPReset;
        RegGainI:       return GainIReset;
        RegGainD:       return GainDReset;
        default:        return SpeedScaleReset;
      endcase
    end
    if (r == 3) begin
      if (idx == RegTargetSpeed) return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      return CfgW'($urandom);
    end
    case (idx)
      RegTargetSpeed: return CfgW'($urandom_range(0, 2048)) - 16'd1024;
      RegSpeedScale:  return CfgW'($urandom_range(0, 12000));
      default:        return CfgW'($urandom_range(0, 2500));
    endcase
  endfunction

  // Offer one tick and hold it until taken; valid stays up when no gap follows
  task automatic send_tick(input logic [CountW-1:0] cnt, input logic typed,
                           input tick_result_t typed_res);
    tick_result_t r;
    int gap;
    r = pid_tick(cnt);
    if (typed) r = typed_res;
    cfg_valid <= 1'b0;
    in_valid <= 1'b1;
    encoder_count <= cnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_ticks.push_back(r);
    last_count = cnt;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write one register; called only once the loop has drained
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    int gap;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    gap = idle_len();
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop the tick valid and hold until every predicted result has come back
  task automatic drain_ticks();
    in_valid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Result side: random back-pressure, with stretches of steady readiness
  int ready_hold = 0;
  always @(posedge clk) begin
    int n;
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (calm || $urandom_range(0, 1) == 0) begin
      out_ready <= 1'b1;
      ready_hold <= $urandom_range(0, 6);
    end else begin
      n = idle_len();
      out_ready <= (n == 0);
      ready_hold <= (n == 0) ? 0 : n - 1;
    end
  end

  // Compare every result transaction with the oldest prediction
  always @(posedge clk) begin
    tick_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_ticks.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, actual speed %0d drive %0d",
                 $time, measured_speed, drive_value);
      end else begin
        want = pending_ticks.pop_front();
        check_field("measured_speed", $signed(want.speed), $signed(measured_speed));
        check_field("drive_value", $signed(want.drive), $signed(drive_value));
        check_field("pwm_compare", want.compare, pwm_compare);
        check_field("reverse_pin", want.rev, reverse_pin);
        check_field("brake", want.brk, brake);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    stim_row_t directed[$];
    row_kind_t prev_kind;
    int spin, r;
    logic [CountW-1:0] cnt;

    pid_target = TargetSpeedReset;
    pid_kp = GainPReset;
    pid_ki = GainIReset;
    pid_kd = GainDReset;
    pid_scale = SpeedScaleReset;
    pid_prev_count = '0;
    pid_err1 = '0;
    pid_err2 = '0;
    pid_acc = '0;

    directed = '{
      // first tick after reset: whole count is the delta, default gains drive -7
      typed_row(16'h0000, res(16'sd0, -8'sd7, 10'd920, 1'b1, 1'b0)),
      tick_row(16'h7FFF),
      tick_row(16'h8000),
      tick_row(16'h0123),
      tick_row(16'hFFFB),
      // spare indexes: writes must leave the loop untouched
      reg_row(RegSpare5, 16'hFFFF),
      reg_row(RegSpare6, 16'h0000),
      reg_row(RegSpare7, 16'h5A5A),
      tick_row(16'h0150),
      // full gains, top target, no feedback: accumulator pinned high
      reg_row(RegTargetSpeed, 16'h7FFF),
      reg_row(RegGainP, 16'hFFFF),
      reg_row(RegGainI, 16'hFFFF),
      reg_row(RegGainD, 16'hFFFF),
      reg_row(RegSpeedScale, 16'h0000),
      tick_row(16'h5555),
      tick_row(16'hAAAA),
      typed_row(16'h1111, res(16'sd0, -8'sd99, 10'd0, 1'b1, 1'b0)),
      // bottom target: accumulator pinned low, full positive drive
      reg_row(RegTargetSpeed, 16'h8000),
      tick_row(16'h2222),
      tick_row(16'h3333),
      typed_row(16'h4444, res(16'sd0, 8'sd99, 10'd990, 1'b0, 1'b0)),
      // zero gains freeze the drive; full scale shows speed saturation and floor
      reg_row(RegGainP, 16'h0000),
      reg_row(RegGainI, 16'h0000),
      reg_row(RegGainD, 16'h0000),
      reg_row(RegSpeedScale, 16'hFFFF),
      reg_row(RegTargetSpeed, 16'h0000),
      tick_row(16'h0000),
      typed_row(16'h7FFF, res(16'sd32512, 8'sd99, 10'd990, 1'b0, 1'b0)),
      typed_row(16'hFFFF, res(-16'sd32512, 8'sd99, 10'd990, 1'b0, 1'b0)),
      typed_row(16'h0000, res(16'sd255, 8'sd99, 10'd990, 1'b0, 1'b0)),
      typed_row(16'hFFFF, res(-16'sd256, 8'sd99, 10'd990, 1'b0, 1'b0)),
      // unit integral gain: the target adds straight onto the accumulator
      reg_row(RegGainI, 16'h0100),
      reg_row(RegSpeedScale, 16'h0000),
      reg_row(RegTargetSpeed, 16'h6300),
      typed_row(16'h0000, res(16'sd0, 8'sd0, 10'd0, 1'b1, 1'b1)),
      // below one percent truncates to zero: still brake
      reg_row(RegTargetSpeed, 16'hFF38),
      typed_row(16'h0001, res(16'sd0, 8'sd0, 10'd0, 1'b1, 1'b1)),
      reg_row(RegTargetSpeed, 16'hFE00),
      typed_row(16'h0002, res(16'sd0, 8'sd2, 10'd20, 1'b0, 1'b0)),
      reg_row(RegTargetSpeed, 16'h0400),
      typed_row(16'h0003, res(16'sd0, -8'sd1, 10'd980, 1'b1, 1'b0))
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part: drain before each run of register writes
    prev_kind = ROW_REG;
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_REG) begin
        if (prev_kind == ROW_TICK) drain_ticks();
        write_reg(directed[i].idx, directed[i].value);
      end else begin
        send_tick(directed[i].value, directed[i].typed, directed[i].res);
      end
      prev_kind = directed[i].kind;
    end

    // Random phases: fresh settings, then mostly a steadily turning encoder
    for (int phase = 0; phase < RandPhases; phase++) begin
      drain_ticks();
      calm = (phase == 3 || phase == 7);
      write_reg(RegTargetSpeed, pick_value(RegTargetSpeed));
      write_reg(RegGainP, pick_value(RegGainP));
      write_reg(RegGainI, pick_value(RegGainI));
      write_reg(RegGainD, pick_value(RegGainD));
      write_reg(RegSpeedScale, pick_value(RegSpeedScale));
      if ($urandom_range(0, 4) == 0)
        write_reg(CfgIdxW'($urandom_range(RegSpare5, RegSpare7)), CfgW'($urandom));
      spin = $urandom_range(0, 800) - 400;
      for (int k = 0; k < TicksPerPhase; k++) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          cnt = last_count + CountW'(spin + $urandom_range(0, 20) - 10);
        end else if (r < 85) begin
          cnt = last_count + CountW'($urandom);
        end else if (r < 92) begin
          case ($urandom_range(0, 3))
            0: cnt = 16'h7FFF;
            1: cnt = 16'h8000;
            2: cnt = 16'h0000;
            default: cnt = 16'hFFFF;
          endcase
        end else begin
          cnt = CountW'($urandom);
        end
        send_tick(cnt, 1'b0, tick_result_t'('0));
      end
    end

    // Wind down: everything back, then leave room for any stray result
    drain_ticks();
    repeat (SettleCycles) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
